FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the Cholesky datapath RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define CHOL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define CHOL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

FILE: hw/rtl/chol_pkg.sv
// Shared types and codes for the 3x3 fixed-point Cholesky block.
// No dependencies.
`default_nettype none
package chol_pkg;

  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_CLAMP = 2'd1,
    ST_DIV0  = 2'd2
  } status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/chol_if.sv
// Valid/ready channels for matrix beats in and factor beats out.
// Depends on chol_pkg.
`default_nettype none
interface chol_in_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a11;
  logic signed [DATA_WIDTH-1:0] a21;
  logic signed [DATA_WIDTH-1:0] a22;
  logic signed [DATA_WIDTH-1:0] a31;
  logic signed [DATA_WIDTH-1:0] a32;
  logic signed [DATA_WIDTH-1:0] a33;

  modport source (output valid, a11, a21, a22, a31, a32, a33, input ready);
  modport sink   (input valid, a11, a21, a22, a31, a32, a33, output ready);
endinterface

interface chol_out_if import chol_pkg::*; #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] l11;
  logic signed [DATA_WIDTH-1:0] l21;
  logic signed [DATA_WIDTH-1:0] l22;
  logic signed [DATA_WIDTH-1:0] l31;
  logic signed [DATA_WIDTH-1:0] l32;
  logic signed [DATA_WIDTH-1:0] l33;
  logic [STATUS_W-1:0]          status;

  modport source (output valid, l11, l21, l22, l31, l32, l33, status, input ready);
  modport sink   (input valid, l11, l21, l22, l31, l32, l33, status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/chol_root.sv
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels alongside. No package dependencies.
`default_nettype none
module chol_root #(
  parameter int RAD_W  = 47,
  parameter int SIDE_W = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_vld,
  input  logic [RAD_W-1:0]                  in_rad,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_vld,
  output logic [(RAD_W + RAD_W % 2)/2-1:0]  out_root,
  output logic [SIDE_W-1:0]                 out_side
);

  localparam int SQE = RAD_W + RAD_W % 2;
  localparam int SQR = SQE / 2;

  logic              vld_r  [SQR];
  logic [SQE-1:0]    rad_r  [SQR];
  logic [SQR+1:0]    rem_r  [SQR];
  logic [SQR-1:0]    root_r [SQR];
  logic [SIDE_W-1:0] side_r [SQR];

  for (genvar k = 0; k < SQR; k++) begin : g_stg
    logic              src_vld;
    logic [SQE-1:0]    src_rad;
    logic [SQR+1:0]    src_rem;
    logic [SQR-1:0]    src_root;
    logic [SIDE_W-1:0] src_side;
    logic [SQR+1:0]    rem2;
    logic [SQR+1:0]    trial;
    logic [SQR+1:0]    rem_nxt;
    logic [SQR-1:0]    root_nxt;

    if (k == 0) begin : g_head
      assign src_vld  = in_vld;
      assign src_rad  = SQE'(in_rad);
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_side = in_side;
    end else begin : g_body
      assign src_vld  = vld_r[k-1];
      assign src_rad  = rad_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_side = side_r[k-1];
    end

    assign rem2  = {src_rem[SQR-1:0], src_rad[SQE-1 -: 2]};
    assign trial = {src_root, 2'b01};

    always_comb begin
      if (rem2 >= trial) begin
        rem_nxt  = rem2 - trial;
        root_nxt = {src_root[SQR-2:0], 1'b1};
      end else begin
        rem_nxt  = rem2;
        root_nxt = {src_root[SQR-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[k]  <= src_rad << 2;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= src_side;
      end
    end
  end

  assign out_vld  = vld_r[SQR-1];
  assign out_root = root_r[SQR-1];
  assign out_side = side_r[SQR-1];

endmodule
`default_nettype wire

FILE: hw/rtl/cholesky_3x3_fixed_point.sv
// Cholesky factor of a symmetric 3x3 matrix in signed fixed point, fully pipelined.
// Depends on chol_pkg, chol_if, chol_root and assert_macros.svh.
//
// One matrix beat is taken every cycle while the output is not stalled, and one factor beat
// leaves per beat taken. Each square root resolves one bit per stage, each divider one
// quotient bit per stage, and the three roots and two divisions lie in series.
// The whole pipe holds while a finished beat waits at the output.
`default_nettype none
`include "assert_macros.svh"
module cholesky_3x3_fixed_point import chol_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  chol_in_if.sink   in_ch,
  chol_out_if.source out_ch
);

  localparam int W     = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int RAD_W = W - 1 + F;
  localparam int SQR   = (RAD_W + RAD_W % 2) / 2;
  localparam int XW    = (SQR > W) ? SQR : W;
  localparam int NW    = 2 * W + 1;
  localparam int DW    = NW - 1 + F;
  localparam int RW    = 2 * W + 2;
  localparam int PW    = 2 * W;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic                clamp;
    logic signed [W-1:0] a21;
    logic signed [W-1:0] a22;
    logic signed [W-1:0] a31;
    logic signed [W-1:0] a32;
    logic signed [W-1:0] a33;
  } sd1_t;

  typedef struct packed {
    logic                clamp;
    logic signed [W-1:0] l11;
    logic signed [W-1:0] a22;
    logic signed [W-1:0] a32;
    logic signed [W-1:0] a33;
  } dd1_t;

  typedef struct packed {
    logic          neg;
    logic          nz;
    logic          ovf;
    logic [DW-1:0] rem;
    logic [W-1:0]  q;
  } ln_t;

  typedef struct packed {
    logic                clamp;
    logic                div0;
    logic signed [W-1:0] l11;
    logic signed [W-1:0] l21;
    logic signed [W-1:0] l31;
    logic signed [W-1:0] a22;
    logic signed [W-1:0] a32;
    logic signed [W-1:0] a33;
  } m1_t;

  typedef struct packed {
    logic                 clamp;
    logic                 div0;
    logic signed [W-1:0]  l11;
    logic signed [W-1:0]  l21;
    logic signed [W-1:0]  l31;
    logic signed [W-1:0]  a33;
    logic signed [NW-1:0] n32;
    logic signed [PW-1:0] q31;
  } sd2_t;

  typedef struct packed {
    logic                 clamp;
    logic                 div0;
    logic signed [W-1:0]  l11;
    logic signed [W-1:0]  l21;
    logic signed [W-1:0]  l31;
    logic signed [W-1:0]  l22;
    logic signed [W-1:0]  a33;
    logic signed [PW-1:0] q31;
  } dd2_t;

  typedef struct packed {
    logic                 clamp;
    logic                 div0;
    logic signed [W-1:0]  l11;
    logic signed [W-1:0]  l21;
    logic signed [W-1:0]  l31;
    logic signed [W-1:0]  l22;
    logic signed [W-1:0]  l32;
    logic signed [W-1:0]  a33;
    logic signed [PW-1:0] q31;
  } f2_t;

  typedef struct packed {
    logic                clamp;
    logic                div0;
    logic signed [W-1:0] l11;
    logic signed [W-1:0] l21;
    logic signed [W-1:0] l31;
    logic signed [W-1:0] l22;
    logic signed [W-1:0] l32;
  } sd3_t;

  typedef struct packed {
    logic signed [W-1:0] l11;
    logic signed [W-1:0] l21;
    logic signed [W-1:0] l22;
    logic signed [W-1:0] l31;
    logic signed [W-1:0] l32;
    logic signed [W-1:0] l33;
    status_t             st;
  } res_t;

  function automatic logic signed [W-1:0] f_sat_root(input logic [SQR-1:0] root);
    logic [XW-1:0] rx;
    rx = XW'(root);
    if (rx > XW'(MAXV)) return MAXV;
    return W'(rx);
  endfunction

  function automatic ln_t f_lane(input logic signed [NW-1:0] n, input logic [W-2:0] piv);
    ln_t           t;
    logic [NW-1:0] mag;
    t.neg = n[NW-1];
    mag   = t.neg ? NW'(-n) : NW'(n);
    t.nz  = |n;
    t.rem = DW'(mag) << F;
    t.ovf = t.rem >= (DW'(piv) << W);
    t.q   = '0;
    return t;
  endfunction

  function automatic ln_t f_dstep(input ln_t t, input logic [W-2:0] piv, input int sh);
    ln_t           r;
    logic [DW-1:0] sd;
    r  = t;
    sd = DW'(piv) << sh;
    if (t.rem >= sd) begin
      r.rem   = t.rem - sd;
      r.q[sh] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] f_quot(input ln_t t, input logic zero);
    if (zero) return t.nz ? (t.neg ? MINV : MAXV) : '0;
    if (t.ovf) return t.neg ? MINV : MAXV;
    if (t.neg) return (t.q[W-1] && (|t.q[W-2:0])) ? MINV : $signed(-t.q);
    return t.q[W-1] ? MAXV : $signed(t.q);
  endfunction

  logic adv;
  logic out_vld_r;
  res_t out_res_r;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // input register
  logic                i_vld_r;
  logic signed [W-1:0] i_a11_r;
  sd1_t                i_sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_vld_r <= 1'b0;
    end else if (adv) begin
      i_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_a11_r      <= in_ch.a11;
      i_sd_r.clamp <= in_ch.a11[W-1];
      i_sd_r.a21   <= in_ch.a21;
      i_sd_r.a22   <= in_ch.a22;
      i_sd_r.a31   <= in_ch.a31;
      i_sd_r.a32   <= in_ch.a32;
      i_sd_r.a33   <= in_ch.a33;
    end
  end

  // root of a11
  logic [RAD_W-1:0] rad1;
  logic             sq1_vld;
  logic [SQR-1:0]   sq1_root;
  sd1_t             sq1_sd;

  assign rad1 = i_sd_r.clamp ? '0 : RAD_W'(i_a11_r[W-2:0]) << F;

  chol_root #(.RAD_W(RAD_W), .SIDE_W($bits(sd1_t))) u_sq1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (i_vld_r),
    .in_rad   (rad1),
    .in_side  (i_sd_r),
    .out_vld  (sq1_vld),
    .out_root (sq1_root),
    .out_side (sq1_sd)
  );

  // divide a21 and a31 by l11
  logic signed [W-1:0] l11_c;
  logic                d1_vld_r [W+1];
  dd1_t                d1_sd_r  [W+1];
  ln_t                 d1_ln_r  [W+1][2];

  assign l11_c = f_sat_root(sq1_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r[0] <= 1'b0;
    end else if (adv) begin
      d1_vld_r[0] <= sq1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_sd_r[0].clamp <= sq1_sd.clamp;
      d1_sd_r[0].l11   <= l11_c;
      d1_sd_r[0].a22   <= sq1_sd.a22;
      d1_sd_r[0].a32   <= sq1_sd.a32;
      d1_sd_r[0].a33   <= sq1_sd.a33;
      d1_ln_r[0][0]    <= f_lane(NW'(sq1_sd.a21), l11_c[W-2:0]);
      d1_ln_r[0][1]    <= f_lane(NW'(sq1_sd.a31), l11_c[W-2:0]);
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_d1
    localparam int SH = W - k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_vld_r[k] <= 1'b0;
      end else if (adv) begin
        d1_vld_r[k] <= d1_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d1_sd_r[k]    <= d1_sd_r[k-1];
        d1_ln_r[k][0] <= f_dstep(d1_ln_r[k-1][0], d1_sd_r[k-1].l11[W-2:0], SH);
        d1_ln_r[k][1] <= f_dstep(d1_ln_r[k-1][1], d1_sd_r[k-1].l11[W-2:0], SH);
      end
    end
  end

  // finish l21 and l31
  logic d1_zero;
  logic m1_vld_r;
  m1_t  m1_r;

  assign d1_zero = (d1_sd_r[W].l11 == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (adv) begin
      m1_vld_r <= d1_vld_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r.clamp <= d1_sd_r[W].clamp;
      m1_r.div0  <= d1_zero;
      m1_r.l11   <= d1_sd_r[W].l11;
      m1_r.l21   <= f_quot(d1_ln_r[W][0], d1_zero);
      m1_r.l31   <= f_quot(d1_ln_r[W][1], d1_zero);
      m1_r.a22   <= d1_sd_r[W].a22;
      m1_r.a32   <= d1_sd_r[W].a32;
      m1_r.a33   <= d1_sd_r[W].a33;
    end
  end

  // products of the first column
  logic                 m2_vld_r;
  m1_t                  m2_r;
  logic signed [PW-1:0] m2_p21_r;
  logic signed [PW-1:0] m2_p31_r;
  logic signed [PW-1:0] m2_p33_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (adv) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r     <= m1_r;
      m2_p21_r <= m1_r.l21 * m1_r.l21;
      m2_p31_r <= m1_r.l31 * m1_r.l21;
      m2_p33_r <= m1_r.l31 * m1_r.l31;
    end
  end

  // radicand of l22, numerator of l32
  logic signed [RW-1:0] r22;
  logic                 m3_vld_r;
  logic [RAD_W-1:0]     m3_rad_r;
  sd2_t                 m3_sd_r;

  assign r22 = RW'(m2_r.a22) - RW'(m2_p21_r >>> F);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else if (adv) begin
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_rad_r      <= r22[RW-1] ? '0 : RAD_W'(r22[W-2:0]) << F;
      m3_sd_r.clamp <= m2_r.clamp | r22[RW-1];
      m3_sd_r.div0  <= m2_r.div0;
      m3_sd_r.l11   <= m2_r.l11;
      m3_sd_r.l21   <= m2_r.l21;
      m3_sd_r.l31   <= m2_r.l31;
      m3_sd_r.a33   <= m2_r.a33;
      m3_sd_r.n32   <= NW'(m2_r.a32) - NW'(m2_p31_r >>> F);
      m3_sd_r.q31   <= m2_p33_r >>> F;
    end
  end

  // root for l22
  logic           sq2_vld;
  logic [SQR-1:0] sq2_root;
  sd2_t           sq2_sd;

  chol_root #(.RAD_W(RAD_W), .SIDE_W($bits(sd2_t))) u_sq2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (m3_vld_r),
    .in_rad   (m3_rad_r),
    .in_side  (m3_sd_r),
    .out_vld  (sq2_vld),
    .out_root (sq2_root),
    .out_side (sq2_sd)
  );

  // divide numerator of l32 by l22
  logic signed [W-1:0] l22_c;
  logic                d2_vld_r [W+1];
  dd2_t                d2_sd_r  [W+1];
  ln_t                 d2_ln_r  [W+1];

  assign l22_c = f_sat_root(sq2_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_vld_r[0] <= 1'b0;
    end else if (adv) begin
      d2_vld_r[0] <= sq2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_sd_r[0].clamp <= sq2_sd.clamp;
      d2_sd_r[0].div0  <= sq2_sd.div0;
      d2_sd_r[0].l11   <= sq2_sd.l11;
      d2_sd_r[0].l21   <= sq2_sd.l21;
      d2_sd_r[0].l31   <= sq2_sd.l31;
      d2_sd_r[0].l22   <= l22_c;
      d2_sd_r[0].a33   <= sq2_sd.a33;
      d2_sd_r[0].q31   <= sq2_sd.q31;
      d2_ln_r[0]       <= f_lane(sq2_sd.n32, l22_c[W-2:0]);
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_d2
    localparam int SH = W - k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_vld_r[k] <= 1'b0;
      end else if (adv) begin
        d2_vld_r[k] <= d2_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d2_sd_r[k] <= d2_sd_r[k-1];
        d2_ln_r[k] <= f_dstep(d2_ln_r[k-1], d2_sd_r[k-1].l22[W-2:0], SH);
      end
    end
  end

  // finish l32
  logic d2_zero;
  logic f2_vld_r;
  f2_t  f2_r;

  assign d2_zero = (d2_sd_r[W].l22 == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f2_vld_r <= d2_vld_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_r.clamp <= d2_sd_r[W].clamp;
      f2_r.div0  <= d2_sd_r[W].div0 | d2_zero;
      f2_r.l11   <= d2_sd_r[W].l11;
      f2_r.l21   <= d2_sd_r[W].l21;
      f2_r.l31   <= d2_sd_r[W].l31;
      f2_r.l22   <= d2_sd_r[W].l22;
      f2_r.l32   <= f_quot(d2_ln_r[W], d2_zero);
      f2_r.a33   <= d2_sd_r[W].a33;
      f2_r.q31   <= d2_sd_r[W].q31;
    end
  end

  // square of l32
  logic                 m4_vld_r;
  f2_t                  m4_r;
  logic signed [PW-1:0] m4_p32_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_vld_r <= 1'b0;
    end else if (adv) begin
      m4_vld_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m4_r     <= f2_r;
      m4_p32_r <= f2_r.l32 * f2_r.l32;
    end
  end

  // radicand of l33
  logic signed [RW-1:0] r33;
  logic                 m5_vld_r;
  logic [RAD_W-1:0]     m5_rad_r;
  sd3_t                 m5_sd_r;

  assign r33 = RW'(m4_r.a33) - RW'(m4_r.q31) - RW'(m4_p32_r >>> F);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m5_vld_r <= 1'b0;
    end else if (adv) begin
      m5_vld_r <= m4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m5_rad_r      <= r33[RW-1] ? '0 : RAD_W'(r33[W-2:0]) << F;
      m5_sd_r.clamp <= m4_r.clamp | r33[RW-1];
      m5_sd_r.div0  <= m4_r.div0;
      m5_sd_r.l11   <= m4_r.l11;
      m5_sd_r.l21   <= m4_r.l21;
      m5_sd_r.l31   <= m4_r.l31;
      m5_sd_r.l22   <= m4_r.l22;
      m5_sd_r.l32   <= m4_r.l32;
    end
  end

  // root for l33
  logic           sq3_vld;
  logic [SQR-1:0] sq3_root;
  sd3_t           sq3_sd;

  chol_root #(.RAD_W(RAD_W), .SIDE_W($bits(sd3_t))) u_sq3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (m5_vld_r),
    .in_rad   (m5_rad_r),
    .in_side  (m5_sd_r),
    .out_vld  (sq3_vld),
    .out_root (sq3_root),
    .out_side (sq3_sd)
  );

  // output register
  res_t res_nxt;

  always_comb begin
    res_nxt.l11 = sq3_sd.l11;
    res_nxt.l21 = sq3_sd.l21;
    res_nxt.l22 = sq3_sd.l22;
    res_nxt.l31 = sq3_sd.l31;
    res_nxt.l32 = sq3_sd.l32;
    res_nxt.l33 = f_sat_root(sq3_root);
    if (sq3_sd.div0) begin
      res_nxt.st = ST_DIV0;
    end else if (sq3_sd.clamp) begin
      res_nxt.st = ST_CLAMP;
    end else begin
      res_nxt.st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= sq3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.l11    = out_res_r.l11;
  assign out_ch.l21    = out_res_r.l21;
  assign out_ch.l22    = out_res_r.l22;
  assign out_ch.l31    = out_res_r.l31;
  assign out_ch.l32    = out_res_r.l32;
  assign out_ch.l33    = out_res_r.l33;
  assign out_ch.status = out_res_r.st;

  `CHOL_ASSERT_IMP(a_stall_src, !in_ch.ready, out_vld_r && !out_ch.ready, "stall without a held beat")
  `CHOL_ASSERT_IMP(a_diag_pos, out_vld_r, !out_res_r.l11[W-1] && !out_res_r.l22[W-1] && !out_res_r.l33[W-1], "negative diagonal")
  `CHOL_ASSERT_IMP(a_zero_piv, out_vld_r && (out_res_r.st != ST_DIV0), (out_res_r.l11 != '0) && (out_res_r.l22 != '0), "zero pivot not flagged")

endmodule
`default_nettype wire
